// ----- rtl/core/vvc_pkg.sv -----
// ----------------------------------------------------------------------------
// vvc_pkg
// Shared types and constants of the variable-length integer codec.
// ----------------------------------------------------------------------------
package vvc_pkg;

  localparam int VAL_W       = 64;
  localparam int NARROW_W    = 32;
  localparam int BYTE_W      = 8;
  localparam int GRP_BITS    = 7;
  localparam int CONT_POS    = 7;
  // Groups needed to cover each width (ceiling of width / 7).
  localparam int MAX_GRP_32  = (NARROW_W + GRP_BITS - 1) / GRP_BITS;
  localparam int MAX_GRP_64  = (VAL_W + GRP_BITS - 1) / GRP_BITS;
  localparam int GRP_IDX_W   = $clog2(MAX_GRP_64);

  typedef logic [GRP_IDX_W-1:0] grp_idx_t;
  typedef logic [GRP_BITS-1:0]  grp_t;
  typedef logic [VAL_W-1:0]     val_t;
  typedef logic [BYTE_W-1:0]    byte_t;

  localparam logic OP_DECODE = 1'b0;
  localparam logic OP_ENCODE = 1'b1;
  localparam logic KIND_DEC  = 1'b0;
  localparam logic KIND_ENC  = 1'b1;
  localparam logic MODE_32   = 1'b0;
  localparam logic MODE_64   = 1'b1;

  // One result beat.
  typedef struct packed {
    logic  kind;
    val_t  value;
    byte_t data;
    logic  last;
    logic  overflow;
  } result_t;

  // Encoder status toward the output stage.
  typedef struct packed {
    logic    busy;
    result_t res;
  } enc_stat_t;

endpackage

// ----- rtl/core/vvc_if.sv -----
// ----------------------------------------------------------------------------
// vvc_in_if / vvc_out_if
// Valid/ready channels of the codec: item in, result out.
// ----------------------------------------------------------------------------
interface vvc_in_if;
  import vvc_pkg::*;

  logic  valid;
  logic  ready;
  logic  operation;
  logic  long_mode;
  byte_t in_byte;
  val_t  in_value;

  modport source (output valid, operation, long_mode, in_byte, in_value, input ready);
  modport sink   (input valid, operation, long_mode, in_byte, in_value, output ready);
endinterface

interface vvc_out_if;
  import vvc_pkg::*;

  logic  valid;
  logic  ready;
  logic  out_kind;
  val_t  out_value;
  byte_t out_byte;
  logic  out_last;
  logic  out_overflow;

  modport source (output valid, out_kind, out_value, out_byte, out_last, out_overflow,
                  input ready);
  modport sink   (input valid, out_kind, out_value, out_byte, out_last, out_overflow,
                  output ready);
endinterface

// ----- rtl/core/vvc_decoder.sv -----
// ----------------------------------------------------------------------------
// vvc_decoder
// Accumulate one 7-bit group per accepted byte; report value or overflow.
// ----------------------------------------------------------------------------
module vvc_decoder (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             go,
  input  logic             long_mode,
  input  vvc_pkg::byte_t   in_byte,
  output logic             res_valid,
  output vvc_pkg::result_t res
);
  import vvc_pkg::*;

  val_t     acc_r, acc_nxt;
  grp_idx_t idx_r, idx_nxt;
  logic     mode_r, mode_nxt;

  logic     mode;
  val_t     wmask;
  val_t     placed;
  val_t     merged;
  logic     cont;
  logic     ovf;

  always_comb begin
    mode   = (idx_r == '0) ? long_mode : mode_r;
    wmask  = (mode == MODE_64) ? '1 : {{(VAL_W-NARROW_W){1'b0}}, {NARROW_W{1'b1}}};
    placed = '0;
    // Place the group at its slot; one slot per group index.
    for (int i = 0; i < MAX_GRP_64; i++) begin
      if (idx_r == GRP_IDX_W'(i)) begin
        placed = VAL_W'(in_byte[GRP_BITS-1:0]) << (GRP_BITS * i);
      end
    end
    merged = (acc_r | placed) & wmask;
    cont   = in_byte[CONT_POS];
    ovf    = cont && ((mode == MODE_64) ? (idx_r == GRP_IDX_W'(MAX_GRP_64 - 1))
                                        : (idx_r == GRP_IDX_W'(MAX_GRP_32 - 1)));

    res_valid    = go && (!cont || ovf);
    res.kind     = KIND_DEC;
    res.value    = ovf ? '0 : merged;
    res.data     = '0;
    res.last     = 1'b1;
    res.overflow = ovf;

    acc_nxt  = acc_r;
    idx_nxt  = idx_r;
    mode_nxt = mode_r;
    if (go) begin
      mode_nxt = mode;
      if (res_valid) begin
        acc_nxt = '0;
        idx_nxt = '0;
      end else begin
        acc_nxt = merged;
        idx_nxt = idx_r + GRP_IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r  <= '0;
      idx_r  <= '0;
      mode_r <= MODE_32;
    end else begin
      acc_r  <= acc_nxt;
      idx_r  <= idx_nxt;
      mode_r <= mode_nxt;
    end
  end

  // Group index never runs past the last group of the widest mode.
  assert property (@(posedge clk) disable iff (!rst_n)
    idx_r <= GRP_IDX_W'(MAX_GRP_64 - 1))
    else $error("decoder group index out of range");

  // In narrow mode the index stays within the narrow group count.
  assert property (@(posedge clk) disable iff (!rst_n)
    (idx_r != '0 && mode_r == MODE_32) |-> idx_r <= GRP_IDX_W'(MAX_GRP_32 - 1))
    else $error("narrow decode ran past its width");

  // Any result, value or overflow, always clears the partial value.
  assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |=> (idx_r == '0 && acc_r == '0))
    else $error("decode state not cleared after result");
endmodule

// ----- rtl/core/vvc_encoder.sv -----
// ----------------------------------------------------------------------------
// vvc_encoder
// Shift a loaded value out seven bits per byte, low group first.
// ----------------------------------------------------------------------------
module vvc_encoder (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               load,
  input  logic               long_mode,
  input  vvc_pkg::val_t      in_value,
  input  logic               advance,
  output vvc_pkg::enc_stat_t stat
);
  import vvc_pkg::*;

  val_t sh_r, sh_nxt;
  logic busy_r, busy_nxt;
  logic last;

  always_comb begin
    last = (sh_r[VAL_W-1:GRP_BITS] == '0);

    stat.busy         = busy_r;
    stat.res.kind     = KIND_ENC;
    stat.res.value    = '0;
    stat.res.data     = {~last, sh_r[GRP_BITS-1:0]};
    stat.res.last     = last;
    stat.res.overflow = 1'b0;

    sh_nxt   = sh_r;
    busy_nxt = busy_r;
    if (load) begin
      sh_nxt   = (long_mode == MODE_64) ? in_value
                                        : {{(VAL_W-NARROW_W){1'b0}}, in_value[NARROW_W-1:0]};
      busy_nxt = 1'b1;
    end else if (advance && busy_r) begin
      sh_nxt = sh_r >> GRP_BITS;
      if (last) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sh_r <= sh_nxt;
  end

  // A new value is never loaded over one still being sent.
  assert property (@(posedge clk) disable iff (!rst_n)
    load |-> !busy_r)
    else $error("encoder loaded while busy");

  // Sending the final byte frees the encoder.
  assert property (@(posedge clk) disable iff (!rst_n)
    (advance && busy_r && last && !load) |=> !busy_r)
    else $error("encoder stayed busy after final byte");

  // Non-final bytes carry the continuation bit.
  assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (stat.res.data[CONT_POS] == !stat.res.last))
    else $error("continuation bit does not match last flag");
endmodule

// ----- rtl/core/varint_varlong_codec.sv -----
// ----------------------------------------------------------------------------
// varint_varlong_codec
// Unsigned LEB128-style codec for 32-bit and 64-bit integers.
// ----------------------------------------------------------------------------
//  channel   dir  beat contents
//  in_ch     in   operation, long_mode, in_byte, in_value
//  out_ch    out  out_kind, out_value, out_byte, out_last, out_overflow
//
//  Decode: one byte per cycle while the input is ready; a result is registered
//  in the output register, or in the skid register when the output stalls.
//  Encode: load the shift register, then one byte per cycle unless stalled.
//  Reset (rst_n low, synchronous) clears the partial decode, the encoder and
//  the output stage. A stalled output holds the output register; one decode
//  result may wait in a skid register behind it, after which input stalls.
// ----------------------------------------------------------------------------
module varint_varlong_codec (
  input  logic      clk,
  input  logic      rst_n,
  vvc_in_if.sink    in_ch,
  vvc_out_if.source out_ch
);
  import vvc_pkg::*;

  // Output register and one-entry skid for decode results.
  logic    out_valid_r, out_valid_nxt;
  result_t out_r, out_nxt;
  logic    pend_r, pend_nxt;
  result_t pend_res_r, pend_res_nxt;

  logic      slot_free;
  logic      accept;
  logic      dec_go;
  logic      enc_load;
  logic      enc_advance;
  logic      dec_res_valid;
  result_t   dec_res;
  enc_stat_t enc_stat;

  // Input waits while the encoder is sending or a decode result is parked.
  assign in_ch.ready = !enc_stat.busy && !pend_r;
  assign accept      = in_ch.valid && in_ch.ready;
  assign dec_go      = accept && (in_ch.operation == OP_DECODE);
  assign enc_load    = accept && (in_ch.operation == OP_ENCODE);
  assign slot_free   = !out_valid_r || out_ch.ready;
  // Send an encoded byte only when nothing older is waiting.
  assign enc_advance = slot_free && !pend_r && enc_stat.busy;

  vvc_decoder u_dec (
    .clk       (clk),
    .rst_n     (rst_n),
    .go        (dec_go),
    .long_mode (in_ch.long_mode),
    .in_byte   (in_ch.in_byte),
    .res_valid (dec_res_valid),
    .res       (dec_res)
  );

  vvc_encoder u_enc (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (enc_load),
    .long_mode (in_ch.long_mode),
    .in_value  (in_ch.in_value),
    .advance   (enc_advance),
    .stat      (enc_stat)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    pend_nxt      = pend_r;
    pend_res_nxt  = pend_res_r;

    if (slot_free) begin
      // Oldest first: parked result, fresh decode result, encoder byte.
      priority if (pend_r) begin
        out_valid_nxt = 1'b1;
        out_nxt       = pend_res_r;
        pend_nxt      = 1'b0;
      end else if (dec_res_valid) begin
        out_valid_nxt = 1'b1;
        out_nxt       = dec_res;
      end else if (enc_stat.busy) begin
        out_valid_nxt = 1'b1;
        out_nxt       = enc_stat.res;
      end else begin
        out_valid_nxt = 1'b0;
      end
    end else if (dec_res_valid) begin
      // Output stalled: park the decode result.
      pend_nxt     = 1'b1;
      pend_res_nxt = dec_res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      pend_r      <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      pend_r      <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r      <= out_nxt;
    pend_res_r <= pend_res_nxt;
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.out_kind     = out_r.kind;
  assign out_ch.out_value    = out_r.value;
  assign out_ch.out_byte     = out_r.data;
  assign out_ch.out_last     = out_r.last;
  assign out_ch.out_overflow = out_r.overflow;

  // A parked result always sits behind a full output register.
  assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> out_valid_r)
    else $error("skid holds a result while output is empty");

  // Encoder bytes and a parked decode result never overlap.
  assert property (@(posedge clk) disable iff (!rst_n)
    !(pend_r && enc_stat.busy))
    else $error("skid and encoder active together");

  // An overflow result carries a zero value.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.overflow) |-> (out_r.value == '0 && out_r.kind == KIND_DEC))
    else $error("overflow result with nonzero value");

  // A decoded value is always a single, final beat.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.kind == KIND_DEC) |-> out_r.last)
    else $error("decode result not marked last");
endmodule

// ----- test/vvc_codec_monitor.sv -----
// ----------------------------------------------------------------------------
// vvc_codec_monitor
// Watches both codec channels, predicts the result beats of each input beat
// and compares them in order with what the codec sends.
// ----------------------------------------------------------------------------
module vvc_codec_monitor (
  input  logic clk,
  input  logic rst_n,
  vvc_in_if    in_ch,
  vvc_out_if   out_ch,
  output int   err_count,
  output int   pending,
  output int   beats_in,
  output int   dec_seen,
  output int   ovf_seen,
  output int   enc_bytes_seen
);
  timeunit 1ns;
  timeprecision 1ps;
  import vvc_pkg::*;

  localparam int REPORT_LIMIT = 10;

  // Partial decode of the value under way.
  val_t          acc_value;
  logic [6:0]    grp_shift;
  logic          cur_mode;

  result_t       codec_results_due[$];

  initial begin
    err_count      = 0;
    pending        = 0;
    beats_in       = 0;
    dec_seen       = 0;
    ovf_seen       = 0;
    enc_bytes_seen = 0;
  end

  task automatic absorb_byte(input logic mode, input byte_t b);
    val_t        wmask;
    int unsigned width;
    result_t     r;
    if (grp_shift == 0) cur_mode = mode;
    wmask = (cur_mode == MODE_64) ? {VAL_W{1'b1}} : val_t'(32'hFFFF_FFFF);
    width = (cur_mode == MODE_64) ? VAL_W : NARROW_W;
    acc_value = acc_value | ((val_t'(b[GRP_BITS-1:0]) << grp_shift) & wmask);
    if (!b[CONT_POS]) begin
      r = '{kind: KIND_DEC, value: acc_value & wmask, data: '0, last: 1'b1, overflow: 1'b0};
      codec_results_due.push_back(r);
      acc_value = '0;
      grp_shift = '0;
    end else begin
      grp_shift = 7'(grp_shift + GRP_BITS);
      // too many continued groups for the width: flag it and start over
      if (grp_shift >= width) begin
        r = '{kind: KIND_DEC, value: '0, data: '0, last: 1'b1, overflow: 1'b1};
        codec_results_due.push_back(r);
        acc_value = '0;
        grp_shift = '0;
      end
    end
  endtask

  task automatic split_value(input logic mode, input val_t v_in);
    val_t    v;
    logic    done;
    result_t r;
    v    = (mode == MODE_64) ? v_in : {32'h0, v_in[31:0]};
    done = 1'b0;
    for (int n = 0; n < MAX_GRP_64 && !done; n++) begin
      if ((v >> GRP_BITS) == '0) begin
        r = '{kind: KIND_ENC, value: '0, data: {1'b0, v[GRP_BITS-1:0]}, last: 1'b1,
              overflow: 1'b0};
        done = 1'b1;
      end else begin
        r = '{kind: KIND_ENC, value: '0, data: {1'b1, v[GRP_BITS-1:0]}, last: 1'b0,
              overflow: 1'b0};
        v = v >> GRP_BITS;
      end
      codec_results_due.push_back(r);
    end
  endtask

  task automatic check_beat(input result_t got);
    result_t want;
    if (codec_results_due.size() == 0) begin
      if (err_count < REPORT_LIMIT)
        $display("[%0t] unexpected beat: kind=%0d value=%h byte=%h last=%0d ovf=%0d",
                 $realtime, got.kind, got.value, got.data, got.last, got.overflow);
      err_count++;
    end else begin
      want = codec_results_due.pop_front();
      if (got.kind !== want.kind || got.value !== want.value || got.data !== want.data ||
          got.last !== want.last || got.overflow !== want.overflow) begin
        if (err_count < REPORT_LIMIT) begin
          $display("[%0t] mismatch: expected kind=%0d value=%h byte=%h last=%0d ovf=%0d",
                   $realtime, want.kind, want.value, want.data, want.last, want.overflow);
          $display("           actual   kind=%0d value=%h byte=%h last=%0d ovf=%0d",
                   got.kind, got.value, got.data, got.last, got.overflow);
        end
        err_count++;
      end
    end
    if (got.kind == KIND_DEC) begin
      dec_seen++;
      if (got.overflow) ovf_seen++;
    end else begin
      enc_bytes_seen++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      acc_value = '0;
      grp_shift = '0;
      cur_mode  = MODE_32;
      codec_results_due.delete();
    end else begin
      // a result never leaves on the edge that takes its input beat
      if (out_ch.valid && out_ch.ready)
        check_beat('{kind: out_ch.out_kind, value: out_ch.out_value, data: out_ch.out_byte,
                     last: out_ch.out_last, overflow: out_ch.out_overflow});
      if (in_ch.valid && in_ch.ready) begin
        beats_in++;
        if (in_ch.operation == OP_DECODE) absorb_byte(in_ch.long_mode, in_ch.in_byte);
        else split_value(in_ch.long_mode, in_ch.in_value);
      end
    end
    pending = codec_results_due.size();
  end

endmodule

// ----- test/varint_varlong_codec_test.sv -----
// ----------------------------------------------------------------------------
// varint_varlong_codec_test
// Drives encode and decode beats into the codec with random gaps and output
// stalls; a monitor beside the codec predicts and checks every result beat.
// ----------------------------------------------------------------------------
module varint_varlong_codec_test;
  timeunit 1ns;
  timeprecision 1ps;
  import vvc_pkg::*;

  localparam int IDLE_PCT       = 24;    // percent of cycles a side idles
  localparam int RANDOM_ITEMS   = 294;
  localparam int STEADY_LEN     = 60;    // beats in the stretch with no idling
  localparam int WATCHDOG_LIMIT = 2000;  // cycles with no beat on either channel
  localparam int DRAIN_CYCLES   = 16;

  logic clk = 1'b0;
  logic rst_n;

  int   item_no     = 0;
  int   steady_from = 32'h7FFF_FFFF;
  logic steady      = 1'b0;
  int   idle_cycles = 0;

  int   err_count, pending, beats_in, dec_seen, ovf_seen, enc_bytes_seen;

  vvc_in_if  in_ch ();
  vvc_out_if out_ch ();

  varint_varlong_codec dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  vvc_codec_monitor u_monitor (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_ch          (in_ch),
    .out_ch         (out_ch),
    .err_count      (err_count),
    .pending        (pending),
    .beats_in       (beats_in),
    .dec_seen       (dec_seen),
    .ovf_seen       (ovf_seen),
    .enc_bytes_seen (enc_bytes_seen)
  );

  always #5 clk = ~clk;

  // Stall the result channel at random, except inside the steady stretch.
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      out_ch.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // End the run when neither channel moves a beat for too long.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Watchdog: no beat for %0d cycles, %0d results still due",
               idle_cycles, pending);
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Value of random length: shifting right spreads it over 1 to 10 groups.
  function automatic val_t rand_value();
    return {$urandom, $urandom} >> $urandom_range(63);
  endfunction

  // Present one beat, idling first at random, and hold it until taken.
  // valid stays high between back-to-back beats.
  task automatic send_beat(input logic op, input logic mode, input byte_t b, input val_t v);
    steady = (item_no >= steady_from) && (item_no < steady_from + STEADY_LEN);
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.operation <= op;
    in_ch.long_mode <= mode;
    in_ch.in_byte   <= b;
    in_ch.in_value  <= v;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    item_no++;
  endtask

  // Send one encoded value byte by byte. With closed low, every byte keeps
  // its continuation bit so the decode runs past its width. Now and then
  // slip an encode in between; later bytes carry a random, ignored mode.
  task automatic send_varint(input logic mode, input int nbytes, input logic closed);
    logic cont;
    for (int i = 0; i < nbytes; i++) begin
      if (i > 0 && $urandom_range(19) == 0)
        send_beat(OP_ENCODE, 1'($urandom_range(1)), byte_t'($urandom), rand_value());
      cont = !(closed && i == nbytes - 1);
      send_beat(OP_DECODE, (i == 0) ? mode : logic'($urandom_range(1)),
                {cont, 7'($urandom)}, {$urandom, $urandom});
    end
  endtask

  initial begin
    int   pick;
    int   target;
    logic mode;

    in_ch.valid     = 1'b0;
    in_ch.operation = OP_DECODE;
    in_ch.long_mode = MODE_32;
    in_ch.in_byte   = '0;
    in_ch.in_value  = '0;
    rst_n           = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Encode extremes: zero, upper half dropped in 32-bit mode, 64-bit max,
    // and the smallest two-byte value.
    send_beat(OP_ENCODE, MODE_32, 8'h00, 64'h0);
    send_beat(OP_ENCODE, MODE_32, 8'hFF, {VAL_W{1'b1}});
    send_beat(OP_ENCODE, MODE_64, 8'h00, {VAL_W{1'b1}});
    send_beat(OP_ENCODE, MODE_64, 8'hFF, 64'd128);

    // 32-bit maximum whose last group spills past bit 31: high bits are lost.
    repeat (4) send_beat(OP_DECODE, MODE_32, 8'hFF, 64'h0);
    send_beat(OP_DECODE, MODE_32, 8'h7F, 64'h0);

    // 32-bit overflow, with an encode in the middle that must not disturb it.
    repeat (2) send_beat(OP_DECODE, MODE_32, 8'h80, 64'h0);
    send_beat(OP_ENCODE, MODE_64, 8'h80, 64'h7F);
    repeat (3) send_beat(OP_DECODE, MODE_32, 8'h80, 64'h0);

    // Mode latched on the first byte: later bytes ask for 32-bit but the
    // decode keeps going to the 64-bit overflow.
    send_beat(OP_DECODE, MODE_64, 8'h81, 64'h0);
    repeat (9) send_beat(OP_DECODE, MODE_32, 8'hFF, 64'h0);

    // Single zero byte.
    send_beat(OP_DECODE, MODE_64, 8'h00, {VAL_W{1'b1}});

    // Random part: mostly well-formed values, some overflows and stray bytes.
    target      = item_no + RANDOM_ITEMS;
    steady_from = item_no + 120;
    while (item_no < target) begin
      pick = $urandom_range(99);
      mode = 1'($urandom_range(1));
      if (pick < 35)
        send_beat(OP_ENCODE, mode, byte_t'($urandom), rand_value());
      else if (pick < 85)
        send_varint(mode, $urandom_range(1, (mode == MODE_64) ? MAX_GRP_64 : MAX_GRP_32),
                    1'b1);
      else if (pick < 95)
        send_varint(mode, (mode == MODE_64) ? MAX_GRP_64 : MAX_GRP_32, 1'b0);
      else
        send_beat(OP_DECODE, mode, byte_t'($urandom), {$urandom, $urandom});
    end
    in_ch.valid <= 1'b0;

    // Drain: wait for every result due, then a little longer for strays.
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run took %0d input beats in both modes, with gaps and output stalls;",
             beats_in);
    $display("checked %0d decoded values (%0d overflows) and %0d encoded bytes.",
             dec_seen, ovf_seen, enc_bytes_seen);
    if (err_count == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d failures", err_count);
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ----- varint_varlong_codec.f -----
rtl/core/vvc_pkg.sv
rtl/core/vvc_if.sv
rtl/core/vvc_decoder.sv
rtl/core/vvc_encoder.sv
rtl/core/varint_varlong_codec.sv
test/vvc_codec_monitor.sv
test/varint_varlong_codec_test.sv
